### rtl/core/vbpd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbpd_pkg
// Shared types and constants for the variable-byte posting decoder.
// ----------------------------------------------------------------------------
package vbpd_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int OUT_WIDTH   = 32;
  localparam int CNT_WIDTH   = 32;
  localparam int ADDR_WIDTH  = 4;
  localparam int DATA_WIDTH  = 32;

  // register index, taken from paddr[3:2]
  typedef enum logic [1:0] {
    REG_CONT_STYLE = 2'd0,
    REG_LAYOUT     = 2'd1,
    REG_LIST_LEN   = 2'd2,
    REG_UNUSED     = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    LAYOUT_ID_SUM  = 2'd0,
    LAYOUT_RAW     = 2'd1,
    LAYOUT_ID_ONLY = 2'd2,
    LAYOUT_POS_SUM = 2'd3
  } layout_t;

  typedef enum logic {
    CONT_HIGH_BIT = 1'b0,
    CONT_LOW_BIT  = 1'b1
  } cont_style_t;

  typedef enum logic {
    KIND_ID   = 1'b0,
    KIND_FREQ = 1'b1
  } kind_t;

  typedef struct packed {
    logic [OUT_WIDTH-1:0] value;
    kind_t                kind;
    logic                 last;
  } result_t;

endpackage : vbpd_pkg
`default_nettype wire

### rtl/core/varbyte_posting_decoder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// varbyte_posting_decoder
// Decodes a variable-byte posting stream byte by byte, with d-gap and
// position prefix summing, and emits ids and frequencies or positions.
// ----------------------------------------------------------------------------
// output: the result of the byte that ends an integer is registered into the
//   output register, or into the skid register while out_stall holds the output
// throughput: one byte per cycle while in_stall is low, set by the accumulator
//   and list-state feedback loop; a two-entry output buffer holds a stalled result
// reset: synchronous on rst; list state, accumulator and output buffer clear,
//   registers return to high-bit continuation, layout 0 and one posting a list
module varbyte_posting_decoder
  import vbpd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // byte input
  input  wire logic                  in_valid,
  output      logic                  in_stall,
  input  wire logic [7:0]            in_byte,
  // result output
  output      logic                  out_valid,
  input  wire logic                  out_stall,
  output      logic [OUT_WIDTH-1:0]  value,
  output      logic                  kind,
  output      logic                  last_of_list,
  // configuration
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_WIDTH-1:0] paddr,
  input  wire logic [DATA_WIDTH-1:0] pwdata,
  output      logic [DATA_WIDTH-1:0] prdata,
  output      logic                  pready
);

  // configuration registers
  cont_style_t          cont_style;
  layout_t              layout;
  logic [CNT_WIDTH-1:0] list_postings;

  // decode state
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  logic                   second_half, second_half_next;
  logic [VALUE_WIDTH-1:0] id_sum, id_sum_next;
  logic [CNT_WIDTH-1:0]   postings_done, postings_done_next;
  logic [VALUE_WIDTH-1:0] prev_term, prev_term_next;
  logic                   prev_term_valid, prev_term_valid_next;
  logic [VALUE_WIDTH-1:0] pos_sum, pos_sum_next;

  // output buffer
  result_t out_reg, skid_reg;
  logic    skid_valid;

  logic                   in_fire, take;
  logic [6:0]             payload;
  logic                   more;
  logic [VALUE_WIDTH-1:0] acc_shifted;
  logic                   res_valid;
  result_t                res;
  logic                   list_end;
  logic [CNT_WIDTH:0]     done_plus1;
  reg_idx_t               wr_idx, rd_idx;
  logic                   cfg_wr;

  assign pready   = 1'b1;
  assign in_stall = skid_valid;
  assign in_fire  = in_valid && !in_stall;
  assign take     = out_valid && !out_stall;

  // ---------------- configuration port ----------------
  assign cfg_wr = psel && penable && pwrite && pready;
  assign wr_idx = reg_idx_t'(paddr[3:2]);
  assign rd_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cont_style    <= CONT_HIGH_BIT;
      layout        <= LAYOUT_ID_SUM;
      list_postings <= CNT_WIDTH'(1);
    end else if (cfg_wr) begin
      unique case (wr_idx)
        REG_CONT_STYLE: cont_style    <= cont_style_t'(pwdata[0]);
        REG_LAYOUT:     layout        <= layout_t'(pwdata[1:0]);
        REG_LIST_LEN:   list_postings <= pwdata[CNT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (rd_idx)
      REG_CONT_STYLE: prdata[0]           = cont_style;
      REG_LAYOUT:     prdata[1:0]         = layout;
      REG_LIST_LEN:   prdata[CNT_WIDTH-1:0] = list_postings;
      default: ;
    endcase
  end

  // ---------------- byte decode ----------------
  always_comb begin
    if (cont_style == CONT_LOW_BIT) begin
      payload = in_byte[7:1];
      more    = in_byte[0];
    end else begin
      payload = in_byte[6:0];
      more    = in_byte[7];
    end
  end

  assign acc_shifted = {acc[VALUE_WIDTH-8:0], payload};
  assign done_plus1  = {1'b0, postings_done} + (CNT_WIDTH+1)'(1);

  always_comb begin
    acc_next             = acc;
    second_half_next     = second_half;
    id_sum_next          = id_sum;
    postings_done_next   = postings_done;
    prev_term_next       = prev_term;
    prev_term_valid_next = prev_term_valid;
    pos_sum_next         = pos_sum;
    res_valid            = 1'b0;
    res.value            = OUT_WIDTH'(acc_shifted);
    res.kind             = KIND_ID;
    res.last             = 1'b0;
    list_end             = 1'b0;

    if (in_fire) begin
      if (more) begin
        acc_next = acc_shifted;
      end else begin
        acc_next  = '0;
        res_valid = 1'b1;
        if (layout == LAYOUT_ID_ONLY) begin
          second_half_next = 1'b0;
          list_end         = 1'b1;
        end else if (!second_half) begin
          second_half_next = 1'b1;
          if (layout == LAYOUT_ID_SUM) begin
            id_sum_next = id_sum + acc_shifted;
            res.value   = OUT_WIDTH'(id_sum + acc_shifted);
          end else if (layout == LAYOUT_POS_SUM &&
                       !(prev_term_valid && prev_term == acc_shifted)) begin
            // a new term restarts the position sum
            prev_term_next       = acc_shifted;
            prev_term_valid_next = 1'b1;
            pos_sum_next         = '0;
          end
        end else begin
          res.kind         = KIND_FREQ;
          second_half_next = 1'b0;
          list_end         = 1'b1;
          if (layout == LAYOUT_POS_SUM) begin
            pos_sum_next = pos_sum + acc_shifted;
            res.value    = OUT_WIDTH'(pos_sum + acc_shifted);
          end
        end

        if (list_end) begin
          if (done_plus1 >= {1'b0, list_postings}) begin
            res.last             = 1'b1;
            second_half_next     = 1'b0;
            id_sum_next          = '0;
            postings_done_next   = '0;
            prev_term_next       = '0;
            prev_term_valid_next = 1'b0;
            pos_sum_next         = '0;
          end else begin
            postings_done_next = done_plus1[CNT_WIDTH-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc             <= '0;
      second_half     <= 1'b0;
      id_sum          <= '0;
      postings_done   <= '0;
      prev_term       <= '0;
      prev_term_valid <= 1'b0;
      pos_sum         <= '0;
    end else begin
      acc             <= acc_next;
      second_half     <= second_half_next;
      id_sum          <= id_sum_next;
      postings_done   <= postings_done_next;
      prev_term       <= prev_term_next;
      prev_term_valid <= prev_term_valid_next;
      pos_sum         <= pos_sum_next;
    end
  end

  // ---------------- output register and skid ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (res_valid) begin
        out_reg <= res;
      end
    end else if (res_valid) begin
      skid_reg <= res;
    end
  end

  assign value        = out_reg.value;
  assign kind         = out_reg.kind;
  assign last_of_list = out_reg.last;

  // ---------------- assertions ----------------
  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held while output register empty");

  a_blocked_result_to_skid: assert property (@(posedge clk) disable iff (rst)
    (res_valid && out_valid && out_stall) |=> skid_valid)
    else $error("result lost while output stalled");

  a_acc_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && !more) |=> (acc == '0))
    else $error("accumulator not cleared after end of integer");

  a_list_end_clears: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.last) |=> (postings_done == '0 && !second_half &&
                                 !prev_term_valid))
    else $error("list state not cleared at end of list");

endmodule : varbyte_posting_decoder
`default_nettype wire

### test/varbyte_posting_decoder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varbyte_posting_decoder_checker
// Follows register writes and accepted bytes, decodes the stream on its own
// and compares every emitted value, kind and end-of-list flag in order.
// ----------------------------------------------------------------------------
module varbyte_posting_decoder_checker
  import vbpd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            in_byte,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [OUT_WIDTH-1:0]  value,
  input  logic                  kind,
  input  logic                  last_of_list,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output int                    fail_count,
  output int                    pending
);

  result_t                decoded_q[$];
  cont_style_t            style;
  layout_t                layout;
  logic [CNT_WIDTH-1:0]   list_len;
  logic [CNT_WIDTH-1:0]   done_cnt;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] id_sum;
  logic [VALUE_WIDTH-1:0] prev_term;
  logic [VALUE_WIDTH-1:0] pos_sum;
  logic                   second_half;
  logic                   prev_valid;

  function automatic void clear_list();
    second_half = 1'b0;
    id_sum      = '0;
    done_cnt    = '0;
    prev_term   = '0;
    prev_valid  = 1'b0;
    pos_sum     = '0;
  endfunction

  // counts one finished posting, reports whether it closed the list
  function automatic logic close_posting();
    if ({1'b0, done_cnt} + 33'd1 >= {1'b0, list_len}) begin
      clear_list();
      return 1'b1;
    end
    done_cnt = done_cnt + 1'b1;
    return 1'b0;
  endfunction

  task automatic decode_byte(input logic [7:0] b);
    logic [6:0]             grp;
    logic                   more;
    logic [VALUE_WIDTH-1:0] v;
    result_t                r;
    if (style == CONT_HIGH_BIT) begin
      grp  = b[6:0];
      more = b[7];
    end else begin
      grp  = b[7:1];
      more = b[0];
    end
    acc = {acc[VALUE_WIDTH-8:0], 7'b0} + VALUE_WIDTH'(grp);
    if (more) return;
    v   = acc;
    acc = '0;
    r.last = 1'b0;
    if (layout == LAYOUT_ID_ONLY) begin
      second_half = 1'b0;
      r.value     = v;
      r.kind      = KIND_ID;
      r.last      = close_posting();
    end else if (!second_half) begin
      r.kind = KIND_ID;
      if (layout == LAYOUT_ID_SUM) begin
        id_sum  = id_sum + v;
        r.value = id_sum;
      end else begin
        r.value = v;
        // a new term restarts the position sum
        if (layout == LAYOUT_POS_SUM && !(prev_valid && prev_term == v)) begin
          prev_term  = v;
          prev_valid = 1'b1;
          pos_sum    = '0;
        end
      end
      second_half = 1'b1;
    end else begin
      r.kind = KIND_FREQ;
      if (layout == LAYOUT_POS_SUM) begin
        pos_sum = pos_sum + v;
        r.value = pos_sum;
      end else begin
        r.value = v;
      end
      second_half = 1'b0;
      r.last      = close_posting();
    end
    decoded_q.insert(decoded_q.size(), r);
  endtask

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      style      = CONT_HIGH_BIT;
      layout     = LAYOUT_ID_SUM;
      list_len   = 1;
      acc        = '0;
      clear_list();
      decoded_q.delete();
      fail_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CONT_STYLE: style    = cont_style_t'(pwdata[0]);
          REG_LAYOUT:     layout   = layout_t'(pwdata[1:0]);
          REG_LIST_LEN:   list_len = pwdata[CNT_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) decode_byte(in_byte);
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result value %h kind %0d last %0d",
                   $time, value, kind, last_of_list);
        end else begin
          want = decoded_q.pop_front();
          if (want.value !== value || want.kind !== kind || want.last !== last_of_list)
          begin
            fail_count++;
            $display("%0t: expected value %h kind %0d last %0d, got value %h kind %0d last %0d",
                     $time, want.value, want.kind, want.last, value, kind, last_of_list);
          end
        end
      end
    end
    pending = decoded_q.size();
  end

endmodule

### test/varbyte_posting_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varbyte_posting_decoder_tb
// Feeds encoded posting streams through every continuation style and layout,
// with several list lengths, random idle and stall bursts on both channels,
// and leaves the checking to the checker module beside the decoder.
// ----------------------------------------------------------------------------
module varbyte_posting_decoder_tb;
  import vbpd_pkg::*;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  logic [7:0]            in_byte;
  logic                  out_valid;
  logic                  out_stall;
  logic [OUT_WIDTH-1:0]  value;
  logic                  kind;
  logic                  last_of_list;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [DATA_WIDTH-1:0] pwdata;
  logic [DATA_WIDTH-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;

  bit                    idle_on;
  int                    bytes_sent;
  cont_style_t           cur_style;
  layout_t               cur_layout;

  varbyte_posting_decoder i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .kind(kind), .last_of_list(last_of_list),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  varbyte_posting_decoder_checker i_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .value(value), .kind(kind), .last_of_list(last_of_list),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  function automatic int min_groups(input logic [31:0] v);
    int n;
    n = 1;
    while (n < 5 && (v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // most significant group first; padding groups make overlong integers
  task automatic send_int(input logic [31:0] v);
    int         n;
    logic [6:0] grp;
    logic       more;
    n = min_groups(v);
    if ($urandom_range(0, 7) == 0) n += $urandom_range(1, 2);
    for (int k = n - 1; k >= 0; k--) begin
      if (k >= 5) grp = 7'($urandom_range(0, 127));
      else if (k == 4) grp = {3'($urandom_range(0, 7)), v[31:28]};
      else grp = 7'(v >> (7 * k));
      more = (k != 0);
      push_byte(cur_style == CONT_HIGH_BIT ? {more, grp} : {grp, more});
    end
  endtask

  function automatic logic [31:0] pick_value(input bit is_id);
    // few distinct terms so that positions of a repeated term pile up
    if (cur_layout == LAYOUT_POS_SUM && is_id) return $urandom_range(0, 3);
    case ($urandom_range(0, 5))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      3:       return $urandom_range(0, 16383);
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  task automatic send_posting();
    send_int(pick_value(1'b1));
    if (cur_layout != LAYOUT_ID_ONLY) send_int(pick_value(1'b0));
  endtask

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // sender holds off until every predicted result has been taken
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_mode(input cont_style_t s, input layout_t l, input logic [31:0] len);
    cur_style  = s;
    cur_layout = l;
    reg_write(REG_CONT_STYLE, 32'(s));
    reg_write(REG_LAYOUT, 32'(l));
    reg_write(REG_LIST_LEN, len);
  endtask

  // output side stalls in bursts while idling is on
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int          target;
    logic [31:0] len;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_byte    = 8'h0;
    psel       = 1'b0;
    penable    = 1'b0;
    pwrite     = 1'b0;
    paddr      = '0;
    pwdata     = '0;
    idle_on    = 1'b0;
    bytes_sent = 0;
    cur_style  = CONT_HIGH_BIT;
    cur_layout = LAYOUT_ID_SUM;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    idle_on = 1'b1;

    // reset settings: high-bit marks, id sums, one posting per list
    push_byte(8'h00);
    push_byte(8'h7F);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_byte(8'h7F);
    // overlong integer, the leading one is shifted out
    push_byte(8'h81);
    repeat (4) push_byte(8'h80);
    push_byte(8'h00);

    // low-bit marks, ids only, zero list length, write to the unused index
    wait_idle();
    set_mode(CONT_LOW_BIT, LAYOUT_ID_ONLY, 32'h0);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    push_byte(8'hFE);
    push_byte(8'h03);
    push_byte(8'h00);

    // raw pair switched to position sums between id and second value
    wait_idle();
    reg_write(REG_LAYOUT, 32'(LAYOUT_RAW));
    reg_write(REG_LIST_LEN, 32'hFFFF_FFFF);
    cur_layout = LAYOUT_RAW;
    push_byte(8'h04);
    wait_idle();
    reg_write(REG_LAYOUT, 32'(LAYOUT_POS_SUM));
    push_byte(8'h06);
    push_byte(8'h04);
    push_byte(8'h02);
    push_byte(8'h04);
    push_byte(8'h02);
    // ids only taken mid-pair drops the pending second half
    push_byte(8'h04);
    wait_idle();
    reg_write(REG_LAYOUT, 32'(LAYOUT_ID_ONLY));
    push_byte(8'h08);

    for (int p = 0; p < 12; p++) begin
      idle_on = (p < 10);
      case (p % 6)
        0:       len = 32'd1;
        1:       len = 32'd2;
        2:       len = 32'd3;
        3:       len = $urandom_range(4, 9);
        4:       len = 32'hFFFF_FFFF;
        default: len = 32'd0;
      endcase
      wait_idle();
      set_mode(cont_style_t'(p % 2), layout_t'((p / 2) % 4), len);
      if (p == 3) reg_write(REG_UNUSED, $urandom);
      target = bytes_sent + 33;
      while (bytes_sent < target) begin
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        else send_posting();
      end
    end

    in_valid <= 1'b0;
    for (int w = 0; w < 4000 && pending != 0; w++) @(negedge clk);
    repeat (16) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/vbpd_pkg.sv
rtl/core/varbyte_posting_decoder.sv
test/varbyte_posting_decoder_checker.sv
test/varbyte_posting_decoder_tb.sv
